[hdl/ssbs_pkg.sv]
// Shared types and constants for the sorted store with binary search.
package ssbs_pkg;

  // Fixed field widths of the stream payloads.
  localparam int VALUE_W     = 32;
  localparam int OP_W        = 2;
  localparam int POS_W       = 8;
  localparam int CNT_W       = 9;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_FIELD_W = 1 + POS_W + 1 + CNT_W;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Operation codes carried on the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  // Sequencer states of the core.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_RDI,
    ST_SORT_LDI,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DONE
  } state_t;

  // One result item as handed from the core to the output register.
  typedef struct packed {
    logic [CNT_W-1:0] element_count;
    logic             status;
    logic [POS_W-1:0] position;
    logic             found;
  } res_t;

endpackage

[hdl/ssbs_core.sv]
// Store memory with the sort and search sequencer.
module ssbs_core #(
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                ready,
  input  ssbs_pkg::op_t                       op,
  input  logic signed [ssbs_pkg::VALUE_W-1:0] value,
  output logic                                res_valid,
  input  logic                                res_ready,
  output ssbs_pkg::res_t                      res
);
  import ssbs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Value store, one write and one registered read per cycle.
  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] mem_rd_r;
  logic                      we;
  logic [AW-1:0]             wa;
  logic signed [VALUE_W-1:0] wd;
  logic [AW-1:0]             rd_addr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    mem_rd_r <= mem[rd_addr];
  end

  // Sequencer registers.
  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      sorted_r, sorted_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;
  logic [AW-1:0]             i_r, i_nxt;
  logic [AW-1:0]             j_r, j_nxt;
  logic [AW-1:0]             best_idx_r, best_idx_nxt;
  logic signed [VALUE_W-1:0] best_val_r, best_val_nxt;
  logic signed [VALUE_W-1:0] vi_r, vi_nxt;
  logic [CW-1:0]             lo_r, lo_nxt;
  logic [CW-1:0]             hi_r, hi_nxt;
  logic [AW-1:0]             mid_r, mid_nxt;
  logic [AW-1:0]             pos_r, pos_nxt;
  logic                      found_r, found_nxt;
  logic                      status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      sorted_r <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      sorted_r <= sorted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    vi_r       <= vi_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    pos_r      <= pos_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
  end

  // Helpers for the scan and the probe.
  logic          better;
  logic [AW-1:0] scan_best;
  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid_calc;

  assign better    = (mem_rd_r < best_val_r);
  assign scan_best = better ? j_r : best_idx_r;
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r} - {{CW{1'b0}}, 1'b1};
  assign mid_calc  = AW'(mid_sum >> 1);

  // Next state: clear and append, a selection sort on the first search after appends, then binary search.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    sorted_nxt   = sorted_r;
    key_nxt      = key_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    best_idx_nxt = best_idx_r;
    best_val_nxt = best_val_r;
    vi_nxt       = vi_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    pos_nxt      = pos_r;
    found_nxt    = found_r;
    status_nxt   = status_r;
    we           = 1'b0;
    wa           = '0;
    wd           = value;
    rd_addr      = '0;
    ready        = 1'b0;
    res_valid    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        ready = 1'b1;
        if (start) begin
          key_nxt    = value;
          found_nxt  = 1'b0;
          status_nxt = 1'b0;
          pos_nxt    = '0;
          state_nxt  = ST_DONE;
          case (op)
            OP_CLEAR: begin
              count_nxt  = '0;
              sorted_nxt = 1'b1;
            end
            OP_APPEND: begin
              if (count_r < CW'(DEPTH)) begin
                we         = 1'b1;
                wa         = AW'(count_r);
                count_nxt  = count_r + 1'b1;
                sorted_nxt = 1'b0;
              end else begin
                status_nxt = 1'b1;
              end
            end
            OP_SEARCH: begin
              lo_nxt    = '0;
              hi_nxt    = count_r;
              i_nxt     = '0;
              state_nxt = sorted_r ? ST_SRCH_RD : ST_SORT_RDI;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // Start of one pass: fetch the entry at position i.
      ST_SORT_RDI: begin
        rd_addr = i_r;
        if ((CW'(i_r) + 1'b1) < count_r) begin
          state_nxt = ST_SORT_LDI;
        end else begin
          sorted_nxt = 1'b1;
          lo_nxt     = '0;
          hi_nxt     = count_r;
          state_nxt  = ST_SRCH_RD;
        end
      end

      ST_SORT_LDI: begin
        best_val_nxt = mem_rd_r;
        vi_nxt       = mem_rd_r;
        best_idx_nxt = i_r;
        j_nxt        = i_r + 1'b1;
        state_nxt    = ST_SCAN_RD;
      end

      ST_SCAN_RD: begin
        rd_addr   = j_r;
        state_nxt = ST_SCAN_CMP;
      end

      // Keep the smallest value seen so far in this pass.
      ST_SCAN_CMP: begin
        if (better) begin
          best_val_nxt = mem_rd_r;
          best_idx_nxt = j_r;
        end
        if ((CW'(j_r) + 1'b1) < count_r) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_SCAN_RD;
        end else if (scan_best != i_r) begin
          state_nxt = ST_SWAP_A;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_SORT_RDI;
        end
      end

      ST_SWAP_A: begin
        we        = 1'b1;
        wa        = i_r;
        wd        = best_val_r;
        state_nxt = ST_SWAP_B;
      end

      ST_SWAP_B: begin
        we        = 1'b1;
        wa        = best_idx_r;
        wd        = vi_r;
        i_nxt     = i_r + 1'b1;
        state_nxt = ST_SORT_RDI;
      end

      // Probe the midpoint of the live range; hi is one past the right bound.
      ST_SRCH_RD: begin
        if (lo_r < hi_r) begin
          rd_addr   = mid_calc;
          mid_nxt   = mid_calc;
          state_nxt = ST_SRCH_CMP;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_SRCH_CMP: begin
        if (mem_rd_r == key_r) begin
          found_nxt = 1'b1;
          pos_nxt   = mid_r;
          state_nxt = ST_DONE;
        end else begin
          if (key_r > mem_rd_r) begin
            lo_nxt = CW'(mid_r) + 1'b1;
          end else begin
            hi_nxt = CW'(mid_r);
          end
          state_nxt = ST_SRCH_RD;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result fields, reduced to the stream widths.
  assign res.found         = found_r;
  assign res.position      = POS_W'(pos_r);
  assign res.status        = status_r;
  assign res.element_count = CNT_W'(count_r);

endmodule

[hdl/sorted_store_binary_search.sv]
// Top level of the sorted store with binary search: stream ports and output register.
//
//  Channel   Direction  Payload
//  in_*      slave      tuser: operation; tdata: value
//  out_*     master     tdata: found, position, status, element_count
//
// Clear, append and unused codes go from IDLE straight to DONE, which offers the result.
// Each probe of a search in a sorted store reads the midpoint in SRCH_RD and compares it
// in SRCH_CMP, as the store memory has a registered read.
// The first search after appends runs a selection sort of the store first.
// Reset clears the count and marks the store sorted; no clearing pass is needed.
// A result waits in the output register while the next item is transferred in.
module sorted_store_binary_search #(
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ssbs_pkg::IN_TDATA_W-1:0]     in_tdata,  // [31:0] value
  input  logic [ssbs_pkg::OP_W-1:0]           in_tuser,  // [1:0] operation
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] found, [8:1] position, [9] status, [18:10] element_count, [23:19] zero
  output logic [ssbs_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import ssbs_pkg::*;

  logic   core_ready;
  logic   core_res_valid;
  logic   core_res_ready;
  res_t   core_res;
  logic   in_xfer;

  assign in_tready = core_ready;
  assign in_xfer   = in_tvalid && core_ready;

  ssbs_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer),
    .ready     (core_ready),
    .op        (op_t'(in_tuser)),
    .value     (signed'(in_tdata[VALUE_W-1:0])),
    .res_valid (core_res_valid),
    .res_ready (core_res_ready),
    .res       (core_res)
  );

  // Output register, loaded when empty or being drained this cycle.
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  assign core_res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_res_valid && core_res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res_valid && core_res_ready) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, core_res};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
